@@ design/rdwd_pkg.sv @@
// Shared types, codes and helper functions for the run-length delta word decoder.
package rdwd_pkg;

	localparam int ByteW  = 8;
	localparam int WordW  = 16;
	localparam int CountW = 6;
	localparam int TypeW  = 2;

	// Span type codes carried in the low bits of a header byte.
	localparam logic [TypeW-1:0] SPAN_NIB  = 2'd0;
	localparam logic [TypeW-1:0] SPAN_BYTE = 2'd1;
	localparam logic [TypeW-1:0] SPAN_RAW  = 2'd2;
	localparam logic [TypeW-1:0] SPAN_FILL = 2'd3;

	// Decoding phase of the byte stream.
	typedef enum logic [2:0] {
		PH_ENDED   = 3'd0,
		PH_HEADER  = 3'd1,
		PH_NIB     = 3'd2,
		PH_BYTE    = 3'd3,
		PH_RAW_LO  = 3'd4,
		PH_RAW_HI  = 3'd5,
		PH_FILL_LO = 3'd6,
		PH_FILL_HI = 3'd7
	} phase_t;

	// Controller states.
	typedef enum logic {
		ST_ACCEPT = 1'b0,
		ST_EXEC   = 1'b1
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic step;
	} rdwd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic fire;
		logic skip;
		logic emit;
		logic more;
		logic out_free;
	} rdwd_stat_t;

	// Sign-extended 4-bit delta, scaled by four.
	function automatic logic [WordW-1:0] nib_delta(input logic [3:0] n);
		return {{(WordW-6){n[3]}}, n, 2'b00};
	endfunction

	// Sign-extended 8-bit delta, scaled by four.
	function automatic logic [WordW-1:0] byte_delta(input logic [ByteW-1:0] b);
		return {{(WordW-ByteW-2){b[ByteW-1]}}, b, 2'b00};
	endfunction

	// Little-endian 16-bit value, scaled by four and truncated to 16 bits.
	function automatic logic [WordW-1:0] raw_word(input logic [ByteW-1:0] hi,
		input logic [ByteW-1:0] lo);
		return {hi[ByteW-3:0], lo, 2'b00};
	endfunction

endpackage

@@ design/rdwd_in_if.sv @@
// Input channel interface: one source byte per request.
interface rdwd_in_if import rdwd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ByteW-1:0] src_byte;
	logic             stream_start;

	modport source (output valid, output src_byte, output stream_start, input ready);
	modport sink (input valid, input src_byte, input stream_start, output ready);
endinterface

@@ design/rdwd_out_if.sv @@
// Output channel interface: one decoded sample per request.
interface rdwd_out_if import rdwd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [WordW-1:0] value;
	logic                    last_of_run;
	logic                    end_of_stream;

	modport source (output valid, output value, output last_of_run, output end_of_stream,
		input ready);
	modport sink (input valid, input value, input last_of_run, input end_of_stream,
		output ready);
endinterface

@@ design/rle_delta_word_decoder_core.sv @@
// Top level of the run-length delta word decoder.
// A byte is taken into the held-byte register and then decoded by steps; a step that gives
// a result loads it into the output register, and waits while that register is full.
// A new byte is taken only once the last one is through: a byte can give an extra result
// (a second nibble, or each repeat of a fill span, up to 62), and a byte dropped while the
// stream has ended needs no decode step. Reset sets the stream to ended, zeroes the
// accumulator and empties the output register.
module rle_delta_word_decoder_core import rdwd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	rdwd_in_if.sink    data_in,
	rdwd_out_if.source data_out
);

	rdwd_cmd_t  cmd;
	rdwd_stat_t stat;

	// Sequencing of accept and decode steps.
	rdwd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Decode state, arithmetic and output register.
	rdwd_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_valid      (data_in.valid),
		.src_byte      (data_in.src_byte),
		.stream_start  (data_in.stream_start),
		.out_ready     (data_out.ready),
		.out_valid     (data_out.valid),
		.value         (data_out.value),
		.last_of_run   (data_out.last_of_run),
		.end_of_stream (data_out.end_of_stream)
	);

	assign data_in.ready = cmd.accept;

endmodule

@@ design/rdwd_ctrl.sv @@
// Controller state machine: accepts a byte, then steps the datapath until the byte is done.
module rdwd_ctrl import rdwd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  rdwd_stat_t stat,
	output rdwd_cmd_t  cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: a byte that is ignored keeps the controller accepting.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_ACCEPT: begin
				if (stat.fire && !stat.skip) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (cmd.step && !stat.more) begin
					state_d = ST_ACCEPT;
				end
			end
			default: begin
				state_d = ST_ACCEPT;
			end
		endcase
	end

	// Outputs: a step that produces a result waits for a free output register.
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_ACCEPT: begin
				cmd.accept = 1'b1;
			end
			ST_EXEC: begin
				cmd.step = !stat.emit || stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ design/rdwd_datapath.sv @@
// Datapath: stream state, accumulator, per-step decode and the output register.
module rdwd_datapath import rdwd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rdwd_cmd_t               cmd,
	output rdwd_stat_t              stat,
	input  logic                    in_valid,
	input  logic [ByteW-1:0]        src_byte,
	input  logic                    stream_start,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic signed [WordW-1:0] value,
	output logic                    last_of_run,
	output logic                    end_of_stream
);

	phase_t              phase_q;
	logic [TypeW-1:0]    type_q;
	logic [CountW-1:0]   rem_q;
	logic [WordW-1:0]    acc_q;
	logic [ByteW-1:0]    hold_q;
	logic [ByteW-1:0]    byte_q;
	logic                sub_q;
	logic                out_valid_q;
	logic [WordW-1:0]    value_q;
	logic                last_q;
	logic                end_q;

	phase_t              phase_d;
	logic [TypeW-1:0]    type_d;
	logic [CountW-1:0]   rem_d;
	logic [WordW-1:0]    acc_d;
	logic [ByteW-1:0]    hold_d;
	logic                sub_d;
	logic [CountW-1:0]   rem_dec;
	logic [3:0]          nib;
	logic [WordW-1:0]    sum;
	logic                emit;
	logic                more;
	logic [WordW-1:0]    res_value;
	logic                res_last;
	logic                res_end;
	logic                fire;
	logic                out_free;

	assign fire     = cmd.accept && in_valid;
	assign out_free = !out_valid_q || out_ready;
	assign rem_dec  = rem_q - CountW'(1);
	assign nib      = sub_q ? byte_q[7:4] : byte_q[3:0];

	// One decode step on the held byte; each step gives at most one result.
	always_comb begin
		phase_d   = phase_q;
		type_d    = type_q;
		rem_d     = rem_q;
		acc_d     = acc_q;
		hold_d    = hold_q;
		sub_d     = 1'b0;
		emit      = 1'b0;
		more      = 1'b0;
		res_value = acc_q;
		res_last  = 1'b0;
		res_end   = 1'b0;
		sum       = acc_q;
		case (phase_q)
			PH_HEADER: begin
				rem_d  = byte_q[7:2];
				type_d = byte_q[1:0];
				if (byte_q[7:2] == '0) begin
					emit      = 1'b1;
					res_value = '0;
					res_last  = 1'b1;
					res_end   = 1'b1;
					phase_d   = PH_ENDED;
				end else begin
					case (byte_q[1:0])
						SPAN_NIB:  phase_d = PH_NIB;
						SPAN_BYTE: phase_d = PH_BYTE;
						SPAN_RAW:  phase_d = PH_RAW_LO;
						SPAN_FILL: phase_d = PH_FILL_LO;
						default:   phase_d = PH_FILL_LO;
					endcase
				end
			end
			PH_NIB: begin
				if (rem_q != '0) begin
					sum       = acc_q + nib_delta(nib);
					acc_d     = sum;
					rem_d     = rem_dec;
					emit      = 1'b1;
					res_value = sum;
					res_last  = (rem_dec == '0) || sub_q;
					more      = !sub_q && (rem_dec != '0);
					sub_d     = more;
					if (rem_dec == '0) begin
						phase_d = PH_HEADER;
					end
				end else begin
					phase_d = PH_HEADER;
				end
			end
			PH_BYTE: begin
				if (rem_q != '0) begin
					sum       = acc_q + byte_delta(byte_q);
					acc_d     = sum;
					rem_d     = rem_dec;
					emit      = 1'b1;
					res_value = sum;
					res_last  = 1'b1;
					if (rem_dec == '0) begin
						phase_d = PH_HEADER;
					end
				end else begin
					phase_d = PH_HEADER;
				end
			end
			PH_RAW_LO: begin
				hold_d  = byte_q;
				phase_d = PH_RAW_HI;
			end
			PH_RAW_HI: begin
				acc_d     = raw_word(byte_q, hold_q);
				res_value = raw_word(byte_q, hold_q);
				phase_d   = PH_RAW_LO;
				if (rem_q != '0) begin
					rem_d    = rem_dec;
					emit     = 1'b1;
					res_last = 1'b1;
					if (rem_dec == '0) begin
						phase_d = PH_HEADER;
					end
				end else begin
					phase_d = PH_HEADER;
				end
			end
			PH_FILL_LO: begin
				hold_d  = byte_q;
				phase_d = PH_FILL_HI;
			end
			PH_FILL_HI: begin
				// The same value goes out once per remaining count.
				acc_d     = raw_word(byte_q, hold_q);
				res_value = raw_word(byte_q, hold_q);
				if (rem_q != '0) begin
					rem_d    = rem_dec;
					emit     = 1'b1;
					res_last = (rem_dec == '0);
					more     = (rem_dec != '0);
					if (rem_dec == '0) begin
						phase_d = PH_HEADER;
					end
				end else begin
					phase_d = PH_HEADER;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	// Status toward the controller.
	always_comb begin
		stat          = '0;
		stat.fire     = fire;
		stat.skip     = !stream_start && (phase_q == PH_ENDED);
		stat.emit     = emit;
		stat.more     = more;
		stat.out_free = out_free;
	end

	// Stream state: a start flag clears the accumulator and rearms header decoding.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ENDED;
			type_q  <= '0;
			rem_q   <= '0;
			acc_q   <= '0;
			hold_q  <= '0;
			sub_q   <= 1'b0;
		end else if (fire) begin
			sub_q <= 1'b0;
			if (stream_start) begin
				acc_q   <= '0;
				phase_q <= PH_HEADER;
			end
		end else if (cmd.step) begin
			phase_q <= phase_d;
			type_q  <= type_d;
			rem_q   <= rem_d;
			acc_q   <= acc_d;
			hold_q  <= hold_d;
			sub_q   <= sub_d;
		end
	end

	// Held copy of the accepted byte.
	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q <= src_byte;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.step && emit) begin
			value_q <= res_value;
			last_q  <= res_last;
			end_q   <= res_end;
		end
	end

	assign out_valid     = out_valid_q;
	assign value         = signed'(value_q);
	assign last_of_run   = last_q;
	assign end_of_stream = end_q;

endmodule

@@ design/rdwd_checker.sv @@
// Port-level checker for the decoder core, bound to the top level.
module rdwd_checker import rdwd_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    in_start,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [WordW-1:0] out_value,
	input logic                    out_last,
	input logic                    out_end
);

	// The output register is empty while reset is held.
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last)
			&& $stable(out_end))
		else $error("stalled result changed");

	// An end marker carries a zero value and closes its byte.
	a_end_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_end |-> out_last && out_value == '0)
		else $error("malformed end-of-stream result");

	// A byte that starts a stream is always decoded, so input is held off next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_start |=> !in_ready)
		else $error("stream start byte was not decoded");

endmodule

bind rle_delta_word_decoder_core rdwd_checker u_rdwd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (data_in.valid),
	.in_ready  (data_in.ready),
	.in_start  (data_in.stream_start),
	.out_valid (data_out.valid),
	.out_ready (data_out.ready),
	.out_value (data_out.value),
	.out_last  (data_out.last_of_run),
	.out_end   (data_out.end_of_stream)
);
